// ===== hw/rtl/cidf_pkg.sv =====
// Shared constants, types and state codes for the CAN identifier list filter table.
// Used by cidf_scan, can_id_list_filter_table_core and the cidf_chk checker.
package cidf_pkg;

    // Table geometry.
    localparam int NUM_BANKS       = 28;
    localparam int SLOTS_PER_BANK  = 4;
    localparam int NUM_CONTROLLERS = 3;

    // Field widths.
    localparam int ID_W  = 11;
    localparam int CTL_W = 2;

    // Derived sizes: one memory row holds every slot of one bank.
    localparam int NUM_ROWS = NUM_CONTROLLERS * NUM_BANKS;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int BANK_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int SLOT_W   = (SLOTS_PER_BANK > 1) ? $clog2(SLOTS_PER_BANK) : 1;

    // Operation codes: look the identifier up, or add it.
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_ADD   = 1'b1;

    typedef logic [ID_W-1:0] t_id;
    typedef t_id [SLOTS_PER_BANK-1:0] t_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } t_state;

    // Summary of one pass over a controller's banks.
    typedef struct packed {
        logic              hit;
        logic              has_free;
        logic              free_inact;
        logic [BANK_W-1:0] free_bank;
        logic [SLOT_W-1:0] free_slot;
        t_row              free_row;
    } t_scan_res;

endpackage

// ===== hw/rtl/cidf_scan.sv =====
// Per-bank evaluator: compares one bank row with the identifier and keeps the
// running hit flag and the first place that could take a new identifier. Uses cidf_pkg.
module cidf_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_eval,
    input  logic                 i_active,
    input  logic [cidf_pkg::BANK_W-1:0] i_bank,
    input  cidf_pkg::t_row       i_row,
    input  cidf_pkg::t_id        i_id,
    output cidf_pkg::t_scan_res  o_res
);
    import cidf_pkg::*;

    t_scan_res         r_res;
    logic              hit;
    logic              zero_found;
    logic [SLOT_W-1:0] zero_slot;
    logic              free;

    // Compare all slots of the row; pick the lowest empty slot.
    always_comb begin
        hit        = 1'b0;
        zero_found = 1'b0;
        zero_slot  = '0;
        for (int s = 0; s < SLOTS_PER_BANK; s++) begin
            if (i_row[s] == i_id) begin
                hit = 1'b1;
            end
            if (!zero_found && (i_row[s] == '0)) begin
                zero_found = 1'b1;
                zero_slot  = SLOT_W'(s);
            end
        end
        hit  = hit & i_active;
        free = !i_active || zero_found;
    end

    // Accumulate the result over the banks in scan order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_clear) begin
            r_res <= '0;
        end else if (i_eval) begin
            if (hit) begin
                r_res.hit <= 1'b1;
            end
            if (free && !r_res.has_free) begin
                r_res.has_free   <= 1'b1;
                r_res.free_inact <= !i_active;
                r_res.free_bank  <= i_bank;
                r_res.free_slot  <= zero_slot;
                r_res.free_row   <= i_row;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/can_id_list_filter_table_core.sv =====
// CAN standard-identifier list filter table. A request for an unknown controller
// skips the bank scan and goes straight to the commit state. One request at a time:
// the bank scan reads one memory row per cycle through the single read port, and a
// new request is taken only after the last one has left the commit state. Reset
// empties every bank at once through the per-bank active flags; the slot memory
// itself needs no clearing pass.
module can_id_list_filter_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [cidf_pkg::CTL_W-1:0]    i_controller,
    input  logic [cidf_pkg::ID_W-1:0]     i_std_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok
);
    import cidf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_func;
    t_id                 r_id;
    logic                r_bad;
    logic [ROW_AW-1:0]   r_base;
    logic [BANK_W-1:0]   r_rd_bank;
    logic                r_eval;
    logic [BANK_W-1:0]   r_eval_bank;
    t_row                r_rd_row;
    logic                r_rd_act;
    logic [NUM_ROWS-1:0] r_bank_act;
    t_row                r_mem [NUM_ROWS];
    logic                r_out_valid;
    logic                r_ok;

    logic                accept;
    logic                ctl_bad;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic                out_free;
    logic                commit;
    logic                ok_val;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    t_row                wr_row;
    t_scan_res           scan_res;

    // Controller numbers start at one.
    assign ctl_bad  = (i_controller == '0) ||
                      ({1'b0, i_controller} > (CTL_W + 1)'(NUM_CONTROLLERS));
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_addr  = r_base + ROW_AW'(r_rd_bank);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ctl_bad ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_bank == BANK_W'(NUM_BANKS - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State-machine outputs and the write-back decision.
    always_comb begin
        accept = (r_state == ST_IDLE) && i_in_valid;
        rd_en  = (r_state == ST_SCAN);
        commit = (r_state == ST_COMMIT) && out_free;
        ok_val = !r_bad && (scan_res.hit || ((r_func == FUNC_ADD) && scan_res.has_free));
        wr_en  = commit && !r_bad && (r_func == FUNC_ADD) && !scan_res.hit &&
                 scan_res.has_free;
        wr_addr = r_base + ROW_AW'(scan_res.free_bank);
        if (scan_res.free_inact) begin
            wr_row    = '0;
            wr_row[0] = r_id;
        end else begin
            wr_row                     = scan_res.free_row;
            wr_row[scan_res.free_slot] = r_id;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_eval      <= 1'b0;
            r_rd_bank   <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= rd_en;
            if (accept) begin
                r_rd_bank <= '0;
                r_bad     <= ctl_bad;
            end else if (rd_en) begin
                r_rd_bank <= r_rd_bank + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_id   <= i_std_id;
            r_base <= ROW_AW'((int'(i_controller) - 1) * NUM_BANKS);
        end
        r_eval_bank <= r_rd_bank;
        if (commit) begin
            r_ok <= ok_val;
        end
    end

    // Bank active flags: cleared by reset, set when a bank takes its first identifier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_act <= '0;
        end else if (wr_en) begin
            r_bank_act[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_act <= r_bank_act[rd_addr];
    end

    // Slot memory: one row per bank, registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_mem[rd_addr];
    end

    // Row evaluation, one bank per cycle.
    cidf_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept),
        .i_eval   (r_eval),
        .i_active (r_rd_act),
        .i_bank   (r_eval_bank),
        .i_row    (r_rd_row),
        .i_id     (r_id),
        .o_res    (scan_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;

endmodule

// ===== hw/rtl/cidf_chk.sv =====
// Port-level checker for can_id_list_filter_table_core, attached with a bind.
// Depends on cidf_pkg for field widths.
module cidf_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  logic                       i_func,
    input  logic [cidf_pkg::CTL_W-1:0] i_controller,
    input  logic [cidf_pkg::ID_W-1:0]  i_std_id,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic                       o_ok
);
    // A result waiting for the consumer holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ok))
        else $error("result changed while stalled");

    // A waiting request keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid &&
            $stable({i_func, i_controller, i_std_id}))
        else $error("request changed while waiting");

    // Only one request is in work: acceptance closes the input side.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request accepted during a scan");

    // A new result appears only at the end of request processing.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without a request in work");

endmodule

bind can_id_list_filter_table_core cidf_chk u_cidf_chk (.*);
